/* src/q2e_pkg.sv */
// Shared types, constants and CORDIC helper functions for the quaternion to Euler angle block.
package q2e_pkg;

    localparam int SUM_W   = 35;
    localparam int SP_W    = 29;
    localparam int ROOT_W  = 29;
    localparam int REM_W   = 30;
    localparam int RAD_W   = 58;
    localparam int NSQ     = 29;
    localparam int CW      = 37;
    localparam int ZW      = 28;
    localparam int ANG_W   = 17;
    localparam int NLANE   = 3;

    localparam logic signed [ZW-1:0]    HALF_PI_Q24 = ZW'(26353589);
    localparam logic signed [ANG_W-1:0] PI_Q13      = ANG_W'(25736);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = ANG_W'(12868);
    localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(64'sd268435456);

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] yz;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] wy;
        logic signed [31:0] zx;
        logic signed [31:0] wz;
        logic signed [31:0] xy;
        logic signed [31:0] zz;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SP_W-1:0]  sp;
        logic                    clamp;
        logic                    pos;
    } arg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = ZW'(13176795);
            1:       a = ZW'(7778716);
            2:       a = ZW'(4110060);
            3:       a = ZW'(2086331);
            4:       a = ZW'(1047214);
            5:       a = ZW'(524117);
            6:       a = ZW'(262123);
            7:       a = ZW'(131069);
            default: a = (i < 24) ? ZW'(64'sd1 <<< (24 - i)) : '0;
        endcase
        return a;
    endfunction

    function automatic cord_t cord_pre(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
        cord_t c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        if (x < 0) begin
            if (y >= 0) begin
                c.x = y;
                c.y = -x;
                c.z = HALF_PI_Q24;
            end
            else begin
                c.x = -y;
                c.y = x;
                c.z = -HALF_PI_Q24;
            end
        end
        return c;
    endfunction

    function automatic cord_t cord_iter(input cord_t c, input int i);
        cord_t                r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx     = c.y >>> i;
        dy     = c.x >>> i;
        r.zero = c.zero;
        if (c.y >= 0) begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + atan_q24(i);
        end
        else begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - atan_q24(i);
        end
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] cord_out(input cord_t c,
                                                         input logic signed [ANG_W-1:0] lim);
        logic signed [ZW-1:0]    s;
        logic signed [ANG_W-1:0] r;
        s = c.z + ZW'(1024);
        r = s[ZW-1:11];
        if (c.zero) begin
            r = '0;
        end
        else if (r > lim) begin
            r = lim;
        end
        else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

/* src/quaternion_to_euler_angles.sv */
// Pipelined quaternion to roll, pitch and yaw converter using CORDIC and a digit-by-digit root.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  input   | in_valid, in_stall, quat_w, quat_x, quat_y, quat_z | in
//  output  | out_valid, out_stall, roll_angle, pitch_angle,   | out
//          | yaw_angle, pitch_clamped                         |
//
// One transaction is accepted per cycle while in_stall is low; the pipeline includes the
// 29 root stages and the CORDIC_STEPS arctangent stages.
// Reset clears only the stage valid bits.
// A stalled output holds its transaction; stages behind it keep filling empty slots,
// so in_stall rises only when every stage holds a transaction.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS    = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                roll_angle,
    output logic signed [14:0]                pitch_angle,
    output logic signed [15:0]                yaw_angle,
    output logic                              pitch_clamped
);
    import q2e_pkg::*;

    localparam int SQ0 = 3;
    localparam int C0  = SQ0 + NSQ;
    localparam int CL  = C0 + CORDIC_STEPS;
    localparam int NST = CL + 2;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    prod_t                   p_reg;
    prod_t                   p_next;
    arg_t                    arg_reg  [1:C0-1];
    arg_t                    arg_next [1:C0-1];
    logic [56:0]             sq_reg;
    logic [56:0]             sq_next;
    logic [REM_W-1:0]        rem_reg  [SQ0:C0-1];
    logic [REM_W-1:0]        rem_next [SQ0:C0-1];
    logic [ROOT_W-1:0]       root_reg [SQ0:C0-1];
    logic [ROOT_W-1:0]       root_next[SQ0:C0-1];
    logic [RAD_W-1:0]        n_reg    [SQ0:C0-1];
    logic [RAD_W-1:0]        n_next   [SQ0:C0-1];
    cord_t                   cord_reg [C0:CL][NLANE];
    cord_t                   cord_next[C0:CL][NLANE];
    logic                    cl_reg   [C0:CL];
    logic                    pos_reg  [C0:CL];
    logic signed [15:0]      roll_reg;
    logic signed [15:0]      roll_next;
    logic signed [14:0]      pitch_reg;
    logic signed [14:0]      pitch_next;
    logic signed [15:0]      yaw_reg;
    logic signed [15:0]      yaw_next;
    logic                    clamp_reg;
    logic signed [15:0]      qw;
    logic signed [15:0]      qx;
    logic signed [15:0]      qy;
    logic signed [15:0]      qz;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    generate
        if (COMPONENT_WIDTH > 16)
        begin : g_wide
            localparam int SH = COMPONENT_WIDTH - 16;
            logic signed [COMPONENT_WIDTH-1:0] tw, tx, ty, tz;
            assign tw = quat_w >>> SH;
            assign tx = quat_x >>> SH;
            assign ty = quat_y >>> SH;
            assign tz = quat_z >>> SH;
            assign qw = tw[15:0];
            assign qx = tx[15:0];
            assign qy = ty[15:0];
            assign qz = tz[15:0];
        end
        else if (COMPONENT_WIDTH < 16)
        begin : g_narrow
            localparam int SH = 16 - COMPONENT_WIDTH;
            assign qw = {quat_w, SH'(0)};
            assign qx = {quat_x, SH'(0)};
            assign qy = {quat_y, SH'(0)};
            assign qz = {quat_z, SH'(0)};
        end
        else
        begin : g_same
            assign qw = 16'(quat_w);
            assign qx = 16'(quat_x);
            assign qy = 16'(quat_y);
            assign qz = 16'(quat_z);
        end
    endgenerate

    always_comb
    begin
        p_next.wx = qw * qx;
        p_next.yz = qy * qz;
        p_next.xx = qx * qx;
        p_next.yy = qy * qy;
        p_next.wy = qw * qy;
        p_next.zx = qz * qx;
        p_next.wz = qw * qz;
        p_next.xy = qx * qy;
        p_next.zz = qz * qz;
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] spw;
        spw = (SUM_W'(p_reg.wy) - SUM_W'(p_reg.zx)) <<< 1;
        arg_next[1].sr    = (SUM_W'(p_reg.wx) + SUM_W'(p_reg.yz)) <<< 1;
        arg_next[1].cr    = ONE_Q28 - ((SUM_W'(p_reg.xx) + SUM_W'(p_reg.yy)) <<< 1);
        arg_next[1].sy    = (SUM_W'(p_reg.wz) + SUM_W'(p_reg.xy)) <<< 1;
        arg_next[1].cy    = ONE_Q28 - ((SUM_W'(p_reg.yy) + SUM_W'(p_reg.zz)) <<< 1);
        arg_next[1].sp    = spw[SP_W-1:0];
        arg_next[1].clamp = (spw >= ONE_Q28) || (spw <= -ONE_Q28);
        arg_next[1].pos   = spw > 0;
    end

    always_comb
    begin
        logic signed [2*SP_W-1:0] prod;
        prod    = arg_reg[1].sp * arg_reg[1].sp;
        sq_next = prod[56:0];
    end

    genvar k, ln;
    generate
        for (k = 2; k < C0; k++)
        begin : g_arg
            assign arg_next[k] = arg_reg[k-1];
        end

        for (k = SQ0; k < C0; k++)
        begin : g_sqrt
            logic [REM_W-1:0]  rem_p;
            logic [ROOT_W-1:0] root_p;
            logic [RAD_W-1:0]  n_p;
            logic [31:0]       rem_t;
            logic [31:0]       trial;
            if (k == SQ0)
            begin : g_first
                assign rem_p  = '0;
                assign root_p = '0;
                assign n_p    = RAD_W'(58'd1 << 56) - RAD_W'(sq_reg);
            end
            else
            begin : g_rest
                assign rem_p  = rem_reg[k-1];
                assign root_p = root_reg[k-1];
                assign n_p    = n_reg[k-1];
            end
            always_comb
            begin
                rem_t = {rem_p, n_p[RAD_W-1:RAD_W-2]};
                trial = {1'b0, root_p, 2'b01};
                n_next[k] = n_p << 2;
                if (rem_t >= trial)
                begin
                    rem_next[k]  = REM_W'(rem_t - trial);
                    root_next[k] = {root_p[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k]  = rem_t[REM_W-1:0];
                    root_next[k] = {root_p[ROOT_W-2:0], 1'b0};
                end
            end
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k]  <= rem_next[k];
                    root_reg[k] <= root_next[k];
                    n_reg[k]    <= n_next[k];
                end
            end
        end

        for (k = 1; k < C0; k++)
        begin : g_arg_ff
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    arg_reg[k] <= arg_next[k];
                end
            end
        end

        for (k = C0; k <= CL; k++)
        begin : g_cord
            if (k == C0)
            begin : g_pre
                assign cord_next[k][0] = cord_pre(CW'(arg_reg[C0-1].sr), CW'(arg_reg[C0-1].cr));
                assign cord_next[k][1] = cord_pre(CW'(arg_reg[C0-1].sp),
                                                  CW'({1'b0, root_reg[C0-1]}));
                assign cord_next[k][2] = cord_pre(CW'(arg_reg[C0-1].sy), CW'(arg_reg[C0-1].cy));
                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        cl_reg[k]  <= arg_reg[C0-1].clamp;
                        pos_reg[k] <= arg_reg[C0-1].pos;
                    end
                end
            end
            else
            begin : g_it
                for (ln = 0; ln < NLANE; ln++)
                begin : g_lane
                    assign cord_next[k][ln] = cord_iter(cord_reg[k-1][ln], k - C0 - 1);
                end
                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        cl_reg[k]  <= cl_reg[k-1];
                        pos_reg[k] <= pos_reg[k-1];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    cord_reg[k] <= cord_next[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        logic signed [ANG_W-1:0] r;
        logic signed [ANG_W-1:0] p;
        logic signed [ANG_W-1:0] y;
        r = cord_out(cord_reg[CL][0], PI_Q13);
        p = cord_out(cord_reg[CL][1], HALF_PI_Q13);
        y = cord_out(cord_reg[CL][2], PI_Q13);
        if (cl_reg[CL])
        begin
            p = pos_reg[CL] ? HALF_PI_Q13 : -HALF_PI_Q13;
        end
        roll_next  = r[15:0];
        pitch_next = p[14:0];
        yaw_next   = y[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg <= p_next;
        end
        if (en[2])
        begin
            sq_reg <= sq_next;
        end
        if (en[NST-1])
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            clamp_reg <= cl_reg[CL];
        end
    end

    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_clamped = clamp_reg;

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pitch_clamped |-> pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868)
        else $error("Clamped pitch is not a quarter turn.");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736)
        else $error("Roll angle out of range.");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
        else $error("Yaw angle out of range.");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && (&v_reg))
        else $error("Input stalled while the pipeline has an empty stage.");

endmodule
